// ===== design/dma4_pkg.sv =====
package dma4_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int CH_SLOTS         = 4;
    localparam int CH_W             = 2;
    localparam int SCAN_W           = CH_W + 1;

    // input actions
    localparam logic [1:0] ACT_REG_WRITE = 2'd0;
    localparam logic [1:0] ACT_TIMING    = 2'd1;
    localparam logic [1:0] ACT_READ_DATA = 2'd2;

    // register selects
    localparam logic [1:0] REG_CTRL  = 2'd0;
    localparam logic [1:0] REG_SRC   = 2'd1;
    localparam logic [1:0] REG_DST   = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_IRQ   = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // address modes
    localparam logic [1:0] MODE_INC    = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    // control bit positions
    localparam int CTRL_DMODE_LO  = 5;
    localparam int CTRL_SMODE_LO  = 7;
    localparam int CTRL_REPEAT    = 9;
    localparam int CTRL_WORD      = 10;
    localparam int CTRL_TIMING_LO = 12;
    localparam int CTRL_IRQ       = 14;
    localparam int CTRL_ENABLE    = 15;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  channel;
        logic [1:0]  reg_select;
        logic [31:0] write_value;
        logic [1:0]  timing;
        logic [31:0] read_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] bus_address;
        logic [31:0] bus_data;
        logic        word_size;
        logic [3:0]  irq_mask;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            reg_wr;
        logic            load_data;
        logic            unit_wr;
        logic            finish;
        logic            emit;
        logic [1:0]      kind;
        logic            last;
    } dp_cmd_t;

    typedef struct packed {
        logic [15:0] ctrl;
        logic        count_zero;
        logic        count_one;
        logic        out_free;
    } dp_status_t;

endpackage

// ===== design/dma4_datapath.sv =====
module dma4_datapath #(
    parameter int COUNT_WIDTH = dma4_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dma4_pkg::req_t      req,
    input  dma4_pkg::dp_cmd_t   cmd,
    output dma4_pkg::dp_status_t status,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dma4_pkg::rsp_t      rsp
);
    import dma4_pkg::*;

    logic [15:0]            ctrl_reg    [CH_SLOTS];
    logic [31:0]            src_reg     [CH_SLOTS];
    logic [31:0]            dst_reg     [CH_SLOTS];
    logic [31:0]            dst_rl_reg  [CH_SLOTS];
    logic [COUNT_WIDTH-1:0] cnt_reg     [CH_SLOTS];
    logic [COUNT_WIDTH-1:0] cnt_rl_reg  [CH_SLOTS];
    logic [31:0]            data_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   rsp_valid_reg;

    logic [15:0]            sel_ctrl;
    logic [COUNT_WIDTH-1:0] sel_cnt;
    logic                   word;
    logic [31:0]            unit;
    logic [1:0]             dmode;
    logic [1:0]             smode;
    logic [31:0]            dst_step;
    logic [31:0]            src_step;

    function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] mode,
                                              input logic [31:0] u);
        logic [31:0] r;
        case (mode)
            MODE_INC, MODE_RELOAD: r = a + u;
            MODE_DEC:              r = a - u;
            default:               r = a;
        endcase
        return r;
    endfunction

    assign sel_ctrl = ctrl_reg[cmd.ch];
    assign sel_cnt  = cnt_reg[cmd.ch];
    assign word     = sel_ctrl[CTRL_WORD];
    assign unit     = word ? 32'd4 : 32'd2;
    assign dmode    = sel_ctrl[CTRL_DMODE_LO +: 2];
    // source reload code means fixed
    assign smode    = (sel_ctrl[CTRL_SMODE_LO +: 2] == MODE_RELOAD) ? MODE_FIXED
                                                                     : sel_ctrl[CTRL_SMODE_LO +: 2];
    assign dst_step = step_addr(dst_reg[cmd.ch], dmode, unit);
    assign src_step = step_addr(src_reg[cmd.ch], smode, unit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                ctrl_reg[i]   <= '0;
                src_reg[i]    <= '0;
                dst_reg[i]    <= '0;
                dst_rl_reg[i] <= '0;
                cnt_reg[i]    <= '0;
                cnt_rl_reg[i] <= '0;
            end
        end
        else if (cmd.reg_wr)
        begin
            case (req.reg_select)
                REG_CTRL: ctrl_reg[cmd.ch] <= req.write_value[15:0];
                REG_SRC:  src_reg[cmd.ch]  <= req.write_value;
                REG_DST:
                begin
                    dst_reg[cmd.ch]    <= req.write_value;
                    dst_rl_reg[cmd.ch] <= req.write_value;
                end
                default:
                begin
                    cnt_reg[cmd.ch]    <= req.write_value[COUNT_WIDTH-1:0];
                    cnt_rl_reg[cmd.ch] <= req.write_value[COUNT_WIDTH-1:0];
                end
            endcase
        end
        else if (cmd.unit_wr)
        begin
            dst_reg[cmd.ch] <= dst_step;
            src_reg[cmd.ch] <= src_step;
            cnt_reg[cmd.ch] <= sel_cnt - COUNT_WIDTH'(1);
        end
        else if (cmd.finish)
        begin
            if (sel_ctrl[CTRL_REPEAT])
            begin
                cnt_reg[cmd.ch] <= cnt_rl_reg[cmd.ch];
                if (dmode == MODE_RELOAD)
                    dst_reg[cmd.ch] <= dst_rl_reg[cmd.ch];
            end
            else
            begin
                ctrl_reg[cmd.ch][CTRL_ENABLE] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
            data_reg <= req.read_data;
    end

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.kind = cmd.kind;
        rsp_next.last = cmd.last;
        case (cmd.kind)
            KIND_READ:
            begin
                rsp_next.bus_address = src_reg[cmd.ch];
                rsp_next.word_size   = word;
            end
            KIND_WRITE:
            begin
                rsp_next.bus_address = dst_reg[cmd.ch];
                rsp_next.bus_data    = word ? data_reg : {16'h0000, data_reg[15:0]};
                rsp_next.word_size   = word;
            end
            KIND_IRQ: rsp_next.irq_mask = 4'b0001 << cmd.ch;
            default:  rsp_next.irq_mask = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp               = rsp_reg;
    assign status.ctrl       = sel_ctrl;
    assign status.count_zero = (sel_cnt == '0);
    assign status.count_one  = (sel_cnt == COUNT_WIDTH'(1));
    assign status.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

// ===== design/dma4_controller.sv =====
module dma4_controller #(
    parameter int NUM_CHANNELS = dma4_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  dma4_pkg::req_t       req,
    input  dma4_pkg::dp_status_t status,
    output dma4_pkg::dp_cmd_t    cmd
);
    import dma4_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NUM_CHANNELS);

    logic [2:0]        state_reg,  state_next;
    logic              busy_reg,   busy_next;
    logic [CH_W-1:0]   active_reg, active_next;
    logic [1:0]        timing_reg, timing_next;
    logic [SCAN_W-1:0] scan_reg,   scan_next;

    logic accept;
    logic match;
    logic wr_allowed;

    assign accept     = req_valid && req_ready;
    assign match      = status.ctrl[CTRL_ENABLE]
                        && (status.ctrl[CTRL_TIMING_LO +: 2] == timing_reg);
    assign wr_allowed = ({1'b0, req.channel} < SCAN_END)
                        && !(busy_reg && (req.channel == active_reg));

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        active_next = active_reg;
        timing_next = timing_reg;
        scan_next   = scan_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.kind    = KIND_DONE;
        cmd.ch      = active_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = status.out_free;
                cmd.ch    = req.channel;
                if (accept)
                begin
                    case (req.action)
                        ACT_REG_WRITE:
                        begin
                            cmd.reg_wr = wr_allowed;
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                        end
                        ACT_TIMING:
                        begin
                            if (!busy_reg)
                            begin
                                timing_next = req.timing;
                                scan_next   = '0;
                                state_next  = S_SCAN;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                                cmd.last = 1'b1;
                            end
                        end
                        ACT_READ_DATA:
                        begin
                            if (busy_reg)
                            begin
                                cmd.load_data = 1'b1;
                                state_next    = S_WRITE;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                                cmd.last = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                cmd.ch = scan_reg[CH_W-1:0];
                if (status.out_free)
                begin
                    if (scan_reg >= SCAN_END)
                    begin
                        // no channel left: report done and go idle
                        busy_next  = 1'b0;
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (!match)
                    begin
                        scan_next = scan_reg + SCAN_W'(1);
                    end
                    else if (status.count_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.emit   = status.ctrl[CTRL_IRQ];
                        cmd.kind   = KIND_IRQ;
                        scan_next  = scan_reg + SCAN_W'(1);
                    end
                    else
                    begin
                        busy_next   = 1'b1;
                        active_next = scan_reg[CH_W-1:0];
                        cmd.emit    = 1'b1;
                        cmd.kind    = KIND_READ;
                        cmd.last    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.unit_wr = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_WRITE;
                    state_next  = status.count_one ? S_FINISH : S_READ;
                end
            end

            S_READ:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_READ;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.emit   = status.ctrl[CTRL_IRQ];
                    cmd.kind   = KIND_IRQ;
                    // resume the scan after the channel that just ended
                    scan_next  = {1'b0, active_reg} + SCAN_W'(1);
                    state_next = S_SCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            active_reg <= '0;
            timing_reg <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            active_reg <= active_next;
            timing_reg <= timing_next;
            scan_reg   <= scan_next;
        end
    end

endmodule

// ===== design/four_channel_dma_engine.sv =====
// Four-channel DMA engine. Each request beat is a register write, a timing event or the
// data of the outstanding bus read; each answers with one or more response beats (bus read
// request, bus write, interrupt, done/acknowledge), the final one flagged by last. One item
// is handled at a time: req_ready is high only while the controller is idle and the
// response register is free. A register write or an ignored item gets one done beat. A timing
// event is accepted, steps past each channel slot that it passes over, and ends with the
// read request or done beat. Read data is accepted, then written, then followed by the next
// read or, on the final unit, by the end of the channel and a scan of the remaining channel
// slots as for a timing event. Each response beat occupies the single output register, so
// a stalled consumer stretches these steps beat for beat.
module four_channel_dma_engine #(
    parameter int NUM_CHANNELS = dma4_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = dma4_pkg::COUNT_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dma4_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dma4_pkg::rsp_t rsp
);
    import dma4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dma4_controller #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .status    (status),
        .cmd       (cmd)
    );

    dma4_datapath #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
